[hdl/mep_pkg.sv]
package mep_pkg;

  // Keying element codes as they arrive on the input channel.
  typedef enum logic [1:0] {
    ELEM_GAP = 2'd0,
    ELEM_DIT = 2'd1,
    ELEM_DAH = 2'd2,
    ELEM_EOW = 2'd3
  } elem_e;

  localparam logic [5:0] WPM_RESET    = 6'd20;
  localparam int unsigned HDR_PAIRS   = 7;
  localparam logic [1:0] END_MARK     = 2'b11;
  localparam int unsigned PAIRS_PER_B = 4;

  // One packet byte written by the front end into the byte queue.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } push_t;

  // Per-packet record: header byte zero and the overflow mark.
  typedef struct packed {
    logic       vld;
    logic [7:0] hdr;
    logic       ovf;
  } desc_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic ring_full;
    logic desc_full;
  } qstat_t;

  // One beat waiting in the output buffer.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } obeat_t;

  // Read that is in flight towards the output buffer.
  typedef struct packed {
    logic       hdr_sel;
    logic [7:0] hdr;
    logic       last;
    logic       ovf;
  } infl_t;

  // ORs a 2-bit pair into a byte; pair 0 sits in the top two bits.
  function automatic logic [7:0] put_pair(input logic [7:0] b, input logic [1:0] bits,
                                          input logic [1:0] slot);
    logic [7:0] r;
    r = b;
    case (slot)
      2'd0:    r[7:6] = b[7:6] | bits;
      2'd1:    r[5:4] = b[5:4] | bits;
      2'd2:    r[3:2] = b[3:2] | bits;
      default: r[1:0] = b[1:0] | bits;
    endcase
    return r;
  endfunction

endpackage

[hdl/morse_element_packet_packer.sv]
// The first beat (header byte zero) goes from the packet record via the in-flight register
// to the output buffer; later beats follow one per cycle while out_ready_i holds.
// Throughput: one element per cycle; the drain side moves one byte per cycle.
// The input stalls only when the byte ring (two packets deep) or the two-entry packet
// record queue is full.
// Reset (rst_ni low, asynchronous) clears all control state and sets words_per_minute to 20.
module morse_element_packet_packer import mep_pkg::*; #(
  parameter int PACKET_BYTES     = 32,
  parameter int PROTOCOL_VERSION = 1
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] element_i,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] packet_byte_o,
  output logic       last_byte_o,
  output logic       overflowed_o
);

  localparam int LEN_W = $clog2(PACKET_BYTES);

  // The front end packs pairs into a held byte and writes each completed byte into the
  // ring. At end of word it writes the final byte and a packet record holding the header
  // byte, the index of the last byte and the overflow mark. The back end replays each
  // packet: header byte from the record, then the ring bytes, so packing of the next
  // word overlaps with draining of the previous one.
  // The ring memory is never cleared: every byte is written before it is read.

  logic [5:0]       wpm_q;
  push_t            push;
  desc_t            desc;
  logic [LEN_W-1:0] desc_len;
  qstat_t           qstat;

  // Keying speed register; the user must write it only while idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpm_q <= WPM_RESET;
    end else if (cfg_we_i) begin
      wpm_q <= cfg_wdata_i;
    end
  end

  mep_front #(
    .PACKET_BYTES     (PACKET_BYTES),
    .PROTOCOL_VERSION (PROTOCOL_VERSION),
    .LEN_W            (LEN_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .element_i  (element_i),
    .wpm_i      (wpm_q),
    .qstat_i    (qstat),
    .push_o     (push),
    .desc_o     (desc),
    .desc_len_o (desc_len)
  );

  mep_back #(
    .PACKET_BYTES (PACKET_BYTES),
    .LEN_W        (LEN_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .desc_i        (desc),
    .desc_len_i    (desc_len),
    .qstat_o       (qstat),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packet_byte_o (packet_byte_o),
    .last_byte_o   (last_byte_o),
    .overflowed_o  (overflowed_o)
  );

endmodule

[hdl/mep_ram.sv]
module mep_ram import mep_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/mep_front.sv]
module mep_front import mep_pkg::*; #(
  parameter int PACKET_BYTES     = 32,
  parameter int PROTOCOL_VERSION = 1,
  parameter int LEN_W            = $clog2(PACKET_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       element_i,
  input  logic [5:0]       wpm_i,
  input  qstat_t           qstat_i,
  output push_t            push_o,
  output desc_t            desc_o,
  output logic [LEN_W-1:0] desc_len_o
);

  localparam int POS_W = $clog2(PAIRS_PER_B * PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] PAIR_LIMIT = POS_W'(PAIRS_PER_B * PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_HDR    = POS_W'(HDR_PAIRS);

  logic [POS_W-1:0] pos_q, pos_d, pos_w, pos_m1;
  logic [7:0]       pend_q, pend_d, pend_w;
  logic [7:0]       hdr_q, hdr_d, hdr_w;
  logic [5:0]       serial_q, serial_d, serial_nx;
  logic             drop_q, drop_d, drop_w;
  logic             new_word, accept;

  assign in_ready_o = !qstat_i.ring_full && !qstat_i.desc_full;
  assign accept     = in_valid_i && in_ready_o;

  // A new word starts from the header: byte one holds the speed, pair 7 is next.
  assign new_word  = (pos_q == '0);
  assign serial_nx = serial_q + 6'd1;
  assign hdr_w     = new_word ? {2'(PROTOCOL_VERSION), serial_nx} : hdr_q;
  assign pos_w     = new_word ? POS_HDR : pos_q;
  assign pend_w    = new_word ? {wpm_i, 2'b00} : pend_q;
  assign drop_w    = new_word ? 1'b0 : drop_q;
  assign pos_m1    = pos_w - POS_W'(1);

  always_comb begin
    pos_d      = pos_q;
    pend_d     = pend_q;
    hdr_d      = hdr_q;
    serial_d   = serial_q;
    drop_d     = drop_q;
    push_o     = '0;
    desc_o     = '0;
    desc_len_o = '0;
    if (accept) begin
      serial_d = new_word ? serial_nx : serial_q;
      hdr_d    = hdr_w;
      pos_d    = pos_w;
      pend_d   = pend_w;
      drop_d   = drop_w;
      if (elem_e'(element_i) != ELEM_EOW) begin
        if (pos_w >= PAIR_LIMIT) begin
          drop_d = 1'b1;
        end else begin
          pos_d = pos_w + POS_W'(1);
          if (pos_w[1:0] == 2'd0) begin
            // The held byte is complete once a pair lands in the next one.
            push_o.vld  = 1'b1;
            push_o.data = pend_w;
            pend_d      = put_pair(8'h00, element_i, 2'd0);
          end else begin
            pend_d = put_pair(pend_w, element_i, pos_w[1:0]);
          end
        end
      end else begin
        push_o.vld  = 1'b1;
        push_o.data = (pos_m1[1:0] != 2'd0) ? put_pair(pend_w, END_MARK, pos_m1[1:0])
                                            : pend_w;
        desc_o.vld  = 1'b1;
        desc_o.hdr  = hdr_w;
        desc_o.ovf  = drop_w;
        desc_len_o  = pos_m1[LEN_W+1:2];
        pos_d       = '0;
        drop_d      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      serial_q <= '0;
      drop_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      serial_q <= serial_d;
      drop_q   <= drop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    hdr_q  <= hdr_d;
  end

endmodule

[hdl/mep_back.sv]
module mep_back import mep_pkg::*; #(
  parameter int PACKET_BYTES = 32,
  parameter int LEN_W        = $clog2(PACKET_BYTES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  input  desc_t            desc_i,
  input  logic [LEN_W-1:0] desc_len_i,
  output qstat_t           qstat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       packet_byte_o,
  output logic             last_byte_o,
  output logic             overflowed_o
);

  // Byte ring holds bytes one upward of up to two packets.
  localparam int RING_AW    = $clog2(PACKET_BYTES) + 1;
  localparam int RING_DEPTH = 1 << RING_AW;

  logic [RING_AW:0]   wptr_q, rptr_q;
  logic               ram_re;
  logic [7:0]         ram_rdata;

  desc_t              desc_q [2];
  logic [LEN_W-1:0]   len_q  [2];
  logic               dwp_q, drp_q;
  logic [1:0]         dcnt_q;

  logic [LEN_W-1:0]   cnt_q;
  infl_t              infl_q, infl_d;
  logic               inf_q;

  obeat_t             ob_q [2];
  logic               owp_q, orp_q;
  logic [1:0]         occ_q;

  logic               have, is_hdr, is_last, issue, pop, dpop;
  logic [1:0]         used;

  assign qstat_o.ring_full = (wptr_q[RING_AW] != rptr_q[RING_AW]) &&
                             (wptr_q[RING_AW-1:0] == rptr_q[RING_AW-1:0]);
  assign qstat_o.desc_full = (dcnt_q == 2'd2);

  mep_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
    .clk_i   (clk_i),
    .we_i    (push_i.vld),
    .waddr_i (wptr_q[RING_AW-1:0]),
    .wdata_i (push_i.data),
    .re_i    (ram_re),
    .raddr_i (rptr_q[RING_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign pop     = out_valid_o && out_ready_i;
  assign used    = occ_q + {1'b0, inf_q};
  assign have    = (dcnt_q != 2'd0);
  assign is_hdr  = (cnt_q == '0);
  assign is_last = (cnt_q == len_q[drp_q]);
  assign issue   = have && ((used < 2'd2) || pop);
  assign ram_re  = issue && !is_hdr;
  assign dpop    = issue && is_last;

  always_comb begin
    infl_d         = infl_q;
    infl_d.hdr_sel = is_hdr;
    infl_d.hdr     = desc_q[drp_q].hdr;
    infl_d.last    = is_last;
    infl_d.ovf     = desc_q[drp_q].ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      dwp_q  <= 1'b0;
      drp_q  <= 1'b0;
      dcnt_q <= '0;
      cnt_q  <= '0;
      inf_q  <= 1'b0;
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      occ_q  <= '0;
    end else begin
      if (push_i.vld) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (ram_re) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (desc_i.vld) begin
        dwp_q <= ~dwp_q;
      end
      if (dpop) begin
        drp_q <= ~drp_q;
      end
      dcnt_q <= dcnt_q + {1'b0, desc_i.vld} - {1'b0, dpop};
      if (issue) begin
        cnt_q <= is_last ? '0 : cnt_q + 1'b1;
      end
      inf_q <= issue;
      if (inf_q) begin
        owp_q <= ~owp_q;
      end
      if (pop) begin
        orp_q <= ~orp_q;
      end
      occ_q <= occ_q + {1'b0, inf_q} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_i.vld) begin
      desc_q[dwp_q] <= desc_i;
      len_q[dwp_q]  <= desc_len_i;
    end
    if (issue) begin
      infl_q <= infl_d;
    end
    if (inf_q) begin
      ob_q[owp_q].data <= infl_q.hdr_sel ? infl_q.hdr : ram_rdata;
      ob_q[owp_q].last <= infl_q.last;
      ob_q[owp_q].ovf  <= infl_q.ovf;
    end
  end

  assign out_valid_o   = (occ_q != 2'd0);
  assign packet_byte_o = ob_q[orp_q].data;
  assign last_byte_o   = ob_q[orp_q].last;
  assign overflowed_o  = ob_q[orp_q].ovf;

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni) used <= 2'd2)
    else $error("output buffer credit exceeded");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.vld |-> !qstat_o.ring_full)
    else $error("byte written into a full ring");
  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (wptr_q != rptr_q))
    else $error("ring read while empty");
  a_desc_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_i.vld |-> (dcnt_q != 2'd2))
    else $error("packet record written into a full queue");

endmodule
